[rtl/mtsd_pkg.sv]
package mtsd_pkg;

   // coordinate width
   localparam int unsigned POS_W     = 16;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned CFG_W     = 16;
   localparam int unsigned SPEED_W   = 16;
   localparam int unsigned HEADING_W = 3;
   localparam int unsigned EVENT_W   = 2;
   localparam int unsigned CSR_IDX_W = 4;

   // ms per second and the bits it needs
   localparam int unsigned MS_PER_S  = 1000;
   localparam int unsigned MUL_W     = 10;

   // |dx| + |dy|/2 fits POS_W+1 bits, times 1000 adds MUL_W bits
   localparam int unsigned SUM_W     = POS_W + 1;
   localparam int unsigned MAN_W     = POS_W + 2;
   localparam int unsigned NUM_W     = SUM_W + MUL_W;
   localparam int unsigned CMP_W     = (MAN_W > CFG_W) ? MAN_W : CFG_W;
   localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

   localparam logic [CFG_W-1:0] STILL_THRESHOLD_RST = 16'd1;
   localparam logic [CFG_W-1:0] STILL_TIME_RST      = 16'd2000;

   localparam logic [CSR_IDX_W-1:0] CSR_STILL_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_TIME      = 4'd1;

   localparam logic [HEADING_W-1:0] HEADING_E    = 3'd0;
   localparam logic [HEADING_W-1:0] HEADING_NE   = 3'd1;
   localparam logic [HEADING_W-1:0] HEADING_N    = 3'd2;
   localparam logic [HEADING_W-1:0] HEADING_NW   = 3'd3;
   localparam logic [HEADING_W-1:0] HEADING_WEST = 3'd4;
   localparam logic [HEADING_W-1:0] HEADING_SW   = 3'd5;
   localparam logic [HEADING_W-1:0] HEADING_S    = 3'd6;
   localparam logic [HEADING_W-1:0] HEADING_SE   = 3'd7;

   localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
   localparam logic [EVENT_W-1:0] EV_START  = 2'd1;
   localparam logic [EVENT_W-1:0] EV_FINISH = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request fields
      logic delta;     // deltas, dt, standing time
      logic eval;      // stop detector, heading, numerator, divider load
      logic div_step;  // one restoring divide step
      logic finish;    // load response registers
   } cmd_type;

endpackage

[rtl/mtsd_ctrl.sv]
module mtsd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mtsd_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                        state_ff;
   logic [mtsd_pkg::DIV_CNT_W-1:0]   div_cnt_ff;
   logic                             rsp_valid_ff;
   logic                             out_free;

   // output register can take a new result
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.delta    = (state_ff == ST_DELTA);
      cmd.eval     = (state_ff == ST_EVAL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.finish   = (state_ff == ST_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DELTA;
               end
            end
            ST_DELTA: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               div_cnt_ff <= mtsd_pkg::DIV_CNT_W'(mtsd_pkg::NUM_W - 1);
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               div_cnt_ff <= div_cnt_ff - 1'b1;
               if (div_cnt_ff == '0) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/mtsd_dp.sv]
module mtsd_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mtsd_pkg::cmd_type                     cmd,
   input  logic                                  csr_write_enable,
   input  logic [mtsd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mtsd_pkg::CFG_W-1:0]            csr_write_data,
   input  logic signed [mtsd_pkg::POS_W-1:0]     req_x_position,
   input  logic signed [mtsd_pkg::POS_W-1:0]     req_y_position,
   input  logic [mtsd_pkg::TIME_W-1:0]           req_time_ms,
   output logic [mtsd_pkg::SPEED_W-1:0]          rsp_speed,
   output logic [mtsd_pkg::HEADING_W-1:0]        rsp_heading,
   output logic [mtsd_pkg::EVENT_W-1:0]          rsp_event_res,
   output logic                                  rsp_braking
);

   localparam int unsigned PW = mtsd_pkg::POS_W;
   localparam int unsigned TW = mtsd_pkg::TIME_W;
   localparam int unsigned NW = mtsd_pkg::NUM_W;
   localparam int unsigned SW = mtsd_pkg::SPEED_W;

   // configuration
   logic [mtsd_pkg::CFG_W-1:0] still_threshold_ff;
   logic [mtsd_pkg::CFG_W-1:0] still_time_ff;

   // tracker state
   logic                  have_position_ff;
   logic                  braking_ff;
   logic [PW-1:0]         last_x_ff;
   logic [PW-1:0]         last_y_ff;
   logic [TW-1:0]         last_time_ff;
   logic [TW-1:0]         last_move_time_ff;

   // captured sample
   logic [PW-1:0]         x_cap_ff;
   logic [PW-1:0]         y_cap_ff;
   logic [TW-1:0]         t_cap_ff;

   // delta stage
   logic [PW:0]           adx_ff;
   logic [PW:0]           ady_ff;
   logic                  dx_neg_ff;
   logic                  dy_neg_ff;
   logic [TW-1:0]         dt_ff;
   logic [TW-1:0]         stood_ff;

   // eval results
   logic [mtsd_pkg::HEADING_W-1:0] heading_ff;
   logic [mtsd_pkg::EVENT_W-1:0]   event_ff;

   // divider
   logic [TW-1:0]         rem_ff;
   logic [NW-1:0]         quo_ff;
   logic [TW-1:0]         rem_in;
   logic [NW-1:0]         quo_in;

   // response registers
   logic [SW-1:0]                  speed_out_ff;
   logic [mtsd_pkg::HEADING_W-1:0] heading_out_ff;
   logic [mtsd_pkg::EVENT_W-1:0]   event_out_ff;
   logic                           braking_out_ff;

   // delta stage logic
   logic [PW:0]           dx_diff;
   logic [PW:0]           dy_diff;
   logic [PW:0]           dx_mag;
   logic [PW:0]           dy_mag;
   logic [TW-1:0]         dt_calc;
   logic [TW-1:0]         stood_calc;

   assign dx_diff = {x_cap_ff[PW-1], x_cap_ff} - {last_x_ff[PW-1], last_x_ff};
   assign dy_diff = {y_cap_ff[PW-1], y_cap_ff} - {last_y_ff[PW-1], last_y_ff};
   assign dx_mag  = dx_diff[PW] ? (~dx_diff + 1'b1) : dx_diff;
   assign dy_mag  = dy_diff[PW] ? (~dy_diff + 1'b1) : dy_diff;
   // time going backwards or standing still gives dt of one
   assign dt_calc    = (t_cap_ff > last_time_ff) ? (t_cap_ff - last_time_ff) : TW'(1);
   assign stood_calc = (t_cap_ff >= last_move_time_ff) ?
                       (t_cap_ff - last_move_time_ff) : '0;

   // eval stage logic
   logic [mtsd_pkg::MAN_W-1:0]     man;
   logic                           moving;
   logic                           stood_long;
   logic [mtsd_pkg::SUM_W-1:0]     half_sum;
   logic [NW-1:0]                  product;
   logic [mtsd_pkg::HEADING_W-1:0] heading_calc;

   assign man        = {1'b0, adx_ff} + {1'b0, ady_ff};
   assign moving     = mtsd_pkg::CMP_W'(man) > mtsd_pkg::CMP_W'(still_threshold_ff);
   assign stood_long = stood_ff >= TW'(still_time_ff);
   assign half_sum   = adx_ff + (ady_ff >> 1);
   assign product    = NW'(half_sum) * NW'(mtsd_pkg::MS_PER_S);

   always_comb begin
      if ({1'b0, adx_ff} >= {ady_ff, 1'b0}) begin
         heading_calc = dx_neg_ff ? mtsd_pkg::HEADING_WEST : mtsd_pkg::HEADING_E;
      end else if ({1'b0, ady_ff} >= {adx_ff, 1'b0}) begin
         heading_calc = dy_neg_ff ? mtsd_pkg::HEADING_S : mtsd_pkg::HEADING_N;
      end else if (!dx_neg_ff && !dy_neg_ff) begin
         heading_calc = mtsd_pkg::HEADING_NE;
      end else if (dx_neg_ff && !dy_neg_ff) begin
         heading_calc = mtsd_pkg::HEADING_NW;
      end else if (dx_neg_ff) begin
         heading_calc = mtsd_pkg::HEADING_SW;
      end else begin
         heading_calc = mtsd_pkg::HEADING_SE;
      end
   end

   // restoring divide step
   logic [TW:0] trial;
   logic [TW:0] trial_diff;
   logic        fits;

   assign trial      = {rem_ff, quo_ff[NW-1]};
   assign trial_diff = trial - {1'b0, dt_ff};
   assign fits       = trial >= {1'b0, dt_ff};
   assign rem_in     = fits ? trial_diff[TW-1:0] : trial[TW-1:0];
   assign quo_in     = {quo_ff[NW-2:0], fits};

   // control state: config and tracker
   always_ff @(posedge clock) begin
      if (reset) begin
         still_threshold_ff <= mtsd_pkg::STILL_THRESHOLD_RST;
         still_time_ff      <= mtsd_pkg::STILL_TIME_RST;
         have_position_ff   <= 1'b0;
         braking_ff         <= 1'b0;
         last_x_ff          <= '0;
         last_y_ff          <= '0;
         last_time_ff       <= '0;
         last_move_time_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               mtsd_pkg::CSR_STILL_THRESHOLD: still_threshold_ff <= csr_write_data;
               mtsd_pkg::CSR_STILL_TIME:      still_time_ff      <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.eval) begin
            last_x_ff        <= x_cap_ff;
            last_y_ff        <= y_cap_ff;
            last_time_ff     <= t_cap_ff;
            have_position_ff <= 1'b1;
            if (!have_position_ff) begin
               last_move_time_ff <= t_cap_ff;
            end else if (moving) begin
               last_move_time_ff <= t_cap_ff;
               braking_ff        <= 1'b0;
            end else if (!braking_ff && stood_long) begin
               braking_ff <= 1'b1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_cap_ff <= req_x_position;
         y_cap_ff <= req_y_position;
         t_cap_ff <= req_time_ms;
      end
      if (cmd.delta) begin
         adx_ff    <= dx_mag;
         ady_ff    <= dy_mag;
         dx_neg_ff <= dx_diff[PW];
         dy_neg_ff <= dy_diff[PW];
         dt_ff     <= dt_calc;
         stood_ff  <= stood_calc;
      end
      if (cmd.eval) begin
         rem_ff <= '0;
         if (!have_position_ff) begin
            heading_ff <= mtsd_pkg::HEADING_E;
            event_ff   <= mtsd_pkg::EV_NONE;
            quo_ff     <= '0;
         end else begin
            heading_ff <= heading_calc;
            quo_ff     <= product;
            if (moving) begin
               event_ff <= braking_ff ? mtsd_pkg::EV_FINISH : mtsd_pkg::EV_NONE;
            end else if (!braking_ff && stood_long) begin
               event_ff <= mtsd_pkg::EV_START;
            end else begin
               event_ff <= mtsd_pkg::EV_NONE;
            end
         end
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.finish) begin
         speed_out_ff   <= (|quo_ff[NW-1:SW]) ? '1 : quo_ff[SW-1:0];
         heading_out_ff <= heading_ff;
         event_out_ff   <= event_ff;
         braking_out_ff <= braking_ff;
      end
   end

   assign rsp_speed     = speed_out_ff;
   assign rsp_heading   = heading_out_ff;
   assign rsp_event_res = event_out_ff;
   assign rsp_braking   = braking_out_ff;

endmodule

[rtl/motion_tracker_stop_detector_unit.sv]
// Each transaction runs capture, delta, eval, the 27-step restoring divider
//   (POS_W + 11 steps) for speed and the output load; a new request is taken
//   only once the previous result has been loaded into the output registers.
// Reset: synchronous, active high; clears tracker state and braking flag,
//   loads still_threshold = 1 and still_time_ms = 2000. No clearing pass.
module motion_tracker_stop_detector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_write_enable,
   input  logic [mtsd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mtsd_pkg::CFG_W-1:0]            csr_write_data,
   // position samples
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [mtsd_pkg::POS_W-1:0]     req_x_position,
   input  logic signed [mtsd_pkg::POS_W-1:0]     req_y_position,
   input  logic [mtsd_pkg::TIME_W-1:0]           req_time_ms,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mtsd_pkg::SPEED_W-1:0]          rsp_speed,
   output logic [mtsd_pkg::HEADING_W-1:0]        rsp_heading,
   output logic [mtsd_pkg::EVENT_W-1:0]          rsp_event_res,
   output logic                                  rsp_braking
);

   // The controller sequences each transaction: capture, delta (|dx|, |dy|,
   // dt, standing time), eval (stop detector, heading, numerator) and the
   // bit-serial divide. The result lands in output registers, so a finished
   // transaction can wait on rsp_stall while the next sample is taken in;
   // that sample only holds in its done state until the output frees up.
   mtsd_pkg::cmd_type cmd;

   mtsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath holds the configuration, the tracker state (last position,
   // time, last movement time, braking), the divider and response registers.
   mtsd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_x_position   (req_x_position),
      .req_y_position   (req_y_position),
      .req_time_ms      (req_time_ms),
      .rsp_speed        (rsp_speed),
      .rsp_heading      (rsp_heading),
      .rsp_event_res    (rsp_event_res),
      .rsp_braking      (rsp_braking)
   );

endmodule

[bench/tb_motion_tracker_stop_detector_unit.sv]
`timescale 1ns / 100ps

module tb_motion_tracker_stop_detector_unit;

   localparam int CLK_HALF_NS    = 5;
   localparam int TIMEOUT_CYCLES = 1_200_000;
   // window after the last result; anything showing up in it is spurious
   localparam int TAIL_CYCLES    = 40;
   localparam int TOTAL_SAMPLES  = 1450;
   localparam int PHASE_SAMPLES  = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam longint unsigned SPEED_MAX = (64'd1 << mtsd_pkg::SPEED_W) - 1;

   // indexes with no register behind them
   localparam logic [mtsd_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 4'd2;
   localparam logic [mtsd_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 4'd15;

   typedef enum logic [2:0] {
      DIR_E, DIR_NE, DIR_N, DIR_NW, DIR_W, DIR_SW, DIR_S, DIR_SE
   } compass_type;

   typedef struct packed {
      logic [mtsd_pkg::SPEED_W-1:0]   speed;
      logic [mtsd_pkg::HEADING_W-1:0] heading;
      logic [mtsd_pkg::EVENT_W-1:0]   event_res;
      logic                           braking;
   } track_result_type;

   // DUT ports, all inputs known from time zero
   logic                              clock            = 1'b0;
   logic                              reset            = 1'b1;
   logic                              csr_write_enable = 1'b0;
   logic [mtsd_pkg::CSR_IDX_W-1:0]    csr_index        = '0;
   logic [mtsd_pkg::CFG_W-1:0]        csr_write_data   = '0;
   logic                              req_valid        = 1'b0;
   logic                              req_stall;
   logic signed [mtsd_pkg::POS_W-1:0] req_x_position   = '0;
   logic signed [mtsd_pkg::POS_W-1:0] req_y_position   = '0;
   logic [mtsd_pkg::TIME_W-1:0]       req_time_ms      = '0;
   logic                              rsp_valid;
   logic                              rsp_stall        = 1'b0;
   logic [mtsd_pkg::SPEED_W-1:0]      rsp_speed;
   logic [mtsd_pkg::HEADING_W-1:0]    rsp_heading;
   logic [mtsd_pkg::EVENT_W-1:0]      rsp_event_res;
   logic                              rsp_braking;

   // tracker mirror: configuration and state as the block should hold them
   logic [mtsd_pkg::CFG_W-1:0]        still_threshold_q = mtsd_pkg::STILL_THRESHOLD_RST;
   logic [mtsd_pkg::CFG_W-1:0]        still_time_q      = mtsd_pkg::STILL_TIME_RST;
   logic                              have_fix          = 1'b0;
   logic signed [mtsd_pkg::POS_W-1:0] fix_x             = '0;
   logic signed [mtsd_pkg::POS_W-1:0] fix_y             = '0;
   logic [mtsd_pkg::TIME_W-1:0]       fix_time          = '0;
   logic [mtsd_pkg::TIME_W-1:0]       move_time         = '0;
   logic                              braking_q         = 1'b0;

   // trajectory generator position, follows every sample sent
   logic signed [mtsd_pkg::POS_W-1:0] walk_x = '0;
   logic signed [mtsd_pkg::POS_W-1:0] walk_y = '0;
   logic [mtsd_pkg::TIME_W-1:0]       walk_t = '0;

   track_result_type track_expect[$];
   int mismatches   = 0;
   int samples_sent = 0;
   int hold_cycles  = 0;   // forced receiver hold-off, counted down below
   int stall_left   = 0;
   bit steady       = 1'b0; // no random gaps on either side while set

   motion_tracker_stop_detector_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_position   (req_x_position),
      .req_y_position   (req_y_position),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_speed        (rsp_speed),
      .rsp_heading      (rsp_heading),
      .rsp_event_res    (rsp_event_res),
      .rsp_braking      (rsp_braking)
   );

   always #CLK_HALF_NS clock = ~clock;

   // Mostly back-to-back, some short gaps, the odd long one.
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic int spread(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // step of exactly mag that never wraps the 16-bit coordinate
   function automatic int toward_center(logic signed [mtsd_pkg::POS_W-1:0] pos, int mag);
      return (pos >= 0) ? int'(pos) - mag : int'(pos) + mag;
   endfunction

   // Advance the tracker mirror by one sample and return the result it gives.
   function automatic track_result_type advance_tracker(
         logic signed [mtsd_pkg::POS_W-1:0] x,
         logic signed [mtsd_pkg::POS_W-1:0] y,
         logic [mtsd_pkg::TIME_W-1:0]       t);
      track_result_type            res;
      int                          dx, dy, ax, ay;
      longint unsigned             dt, num, rate;
      logic [mtsd_pkg::TIME_W-1:0] stood;
      res = '0;
      // first sample after reset only seeds position and time
      if (!have_fix) begin
         have_fix  = 1'b1;
         fix_x     = x;
         fix_y     = y;
         fix_time  = t;
         move_time = t;
         res.braking = braking_q;
         return res;
      end
      dx = int'(x) - int'(fix_x);
      dy = int'(y) - int'(fix_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      // dt against the previous timestamp; backwards or equal time gives 1 ms
      dt = (t >= fix_time) ? 64'(t - fix_time) : 64'd0;
      if (dt == 0) dt = 1;
      num  = 64'(ax + (ay >>> 1));
      rate = num * mtsd_pkg::MS_PER_S / dt;
      res.speed = (rate > SPEED_MAX) ? SPEED_MAX[mtsd_pkg::SPEED_W-1:0]
                                     : rate[mtsd_pkg::SPEED_W-1:0];
      // 8-way compass; a zero delta lands on east
      if (ax >= 2 * ay) res.heading = (dx >= 0) ? DIR_E : DIR_W;
      else if (ay >= 2 * ax) res.heading = (dy >= 0) ? DIR_N : DIR_S;
      else if (dx >= 0) res.heading = (dy >= 0) ? DIR_NE : DIR_SE;
      else res.heading = (dy >= 0) ? DIR_NW : DIR_SW;
      // stop detector on the Manhattan step
      if (ax + ay > int'(still_threshold_q)) begin
         move_time = t;
         if (braking_q) begin
            res.event_res = mtsd_pkg::EV_FINISH;
            braking_q = 1'b0;
         end
      end else if (!braking_q) begin
         stood = (t >= move_time) ? t - move_time : '0;
         if (stood >= still_time_q) begin
            res.event_res = mtsd_pkg::EV_START;
            braking_q = 1'b1;
         end
      end
      fix_x    = x;
      fix_y    = y;
      fix_time = t;
      res.braking = braking_q;
      return res;
   endfunction

   // One request transaction. Valid stays up after acceptance; the next
   // call (or wait_idle) decides whether it drops. Coordinates wrap to 16 bits.
   task automatic send_sample(int x, int y, logic [mtsd_pkg::TIME_W-1:0] t);
      int                                gap;
      logic signed [mtsd_pkg::POS_W-1:0] xs;
      logic signed [mtsd_pkg::POS_W-1:0] ys;
      xs  = mtsd_pkg::POS_W'(x);
      ys  = mtsd_pkg::POS_W'(y);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_x_position <= xs;
      req_y_position <= ys;
      req_time_ms    <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_expect.push_back(advance_tracker(xs, ys, t));
      samples_sent++;
      walk_x = xs;
      walk_y = ys;
      walk_t = t;
   endtask

   // Always lets one edge pass, so valid never gets two updates in a step.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (track_expect.size() != 0);
   endtask

   task automatic write_csr(logic [mtsd_pkg::CSR_IDX_W-1:0] idx,
                            logic [mtsd_pkg::CFG_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         mtsd_pkg::CSR_STILL_THRESHOLD: still_threshold_q = value;
         mtsd_pkg::CSR_STILL_TIME:      still_time_q = value;
         default: ;
      endcase
   endtask

   task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         mismatches++;
      end
   endtask

   // Receiver: forced hold-off first, then random stall bursts.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!steady && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
   end

   // Every accepted response transaction is matched against the oldest
   // outstanding prediction.
   always @(posedge clock) begin
      track_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (track_expect.size() == 0) begin
            $error("unexpected result: speed %0d heading %0d event %0d braking %0d",
                   rsp_speed, rsp_heading, rsp_event_res, rsp_braking);
            mismatches++;
         end else begin
            want = track_expect.pop_front();
            check_field("speed", 32'(want.speed), 32'(rsp_speed));
            check_field("heading", 32'(want.heading), 32'(rsp_heading));
            check_field("event_res", 32'(want.event_res), 32'(rsp_event_res));
            check_field("braking", 32'(want.braking), 32'(rsp_braking));
         end
      end
   end

   // Field extremes, time anomalies, braking start/finish and every heading,
   // all on reset configuration (threshold 1 dm, 2000 ms).
   task automatic test_directed_edges();
      int moves [10][2] = '{'{10, 0}, '{10, 10}, '{0, 10}, '{-10, 10}, '{-10, 0},
                            '{-10, -10}, '{0, -10}, '{10, -10}, '{10, 5}, '{5, 10}};
      int i;
      // seeding transaction at the far corner
      send_sample(-32768, 32767, 0);
      // full-scale diagonal in zero time: dt clamps to 1, speed saturates, SE
      send_sample(32767, -32768, 0);
      // no motion: east, zero speed
      send_sample(32767, -32768, 5);
      // 1 dm creep after 2 s standing -> braking starts
      send_sample(32767, -32767, 2005);
      // clock steps back while braking
      send_sample(32767, -32767, 2004);
      // 2 dm west -> braking finished
      send_sample(32765, -32767, 2010);
      // the eight compass points, then both 2:1 boundaries
      for (i = 0; i < 10; i++)
         send_sample(walk_x + moves[i][0], walk_y + moves[i][1], walk_t + 100);
      // standing up to the top of the time range, then wrap back to zero
      send_sample(walk_x, walk_y, 32'hFFFF_FFFF);
      send_sample(walk_x + 3, walk_y, 0);
      // move at 1000 ms, then stand at an earlier timestamp: standing time 0
      send_sample(walk_x + 5, walk_y, 1000);
      send_sample(walk_x, walk_y, 500);
   endtask

   // Both registers at their extremes plus writes to unmapped indexes.
   task automatic test_csr_extremes();
      wait_idle();
      write_csr(mtsd_pkg::CSR_STILL_THRESHOLD, 16'd0);
      write_csr(mtsd_pkg::CSR_STILL_TIME, 16'd0);
      // zero step brakes immediately, any step releases
      send_sample(walk_x, walk_y, walk_t + 1);
      send_sample(walk_x + 1, walk_y, walk_t + 1);
      // standing with time going back still brakes at a zero hold time
      send_sample(walk_x, walk_y, walk_t - 3);
      wait_idle();
      write_csr(mtsd_pkg::CSR_STILL_THRESHOLD, 16'hFFFF);
      write_csr(mtsd_pkg::CSR_STILL_TIME, 16'hFFFF);
      send_sample(-32768, 0, walk_t + 10);
      // 65535 dm counts as standing, 65536 is movement
      send_sample(32767, 0, walk_t + 1);
      send_sample(-32768, 1, walk_t + 1);
      // stand for the full 65535 ms
      send_sample(-32768, 1, walk_t + 65535);
      wait_idle();
      write_csr(CSR_UNMAPPED_LO, 16'h0000);
      write_csr(CSR_UNMAPPED_HI, 16'h0000);
      // threshold must still be 65535 here
      send_sample(-32766, 1, walk_t + 7);
      send_sample(-32766, 2, walk_t + 70000);
   endtask

   // Receiver holds off while the sender keeps offering back to back, so the
   // block fills up and pushes back on the request side.
   task automatic test_backpressure();
      wait_idle();
      steady = 1'b1;
      hold_cycles = HOLD_OFF_CYCLES;
      repeat (12)
         send_sample(walk_x + spread(20), walk_y + spread(20),
                     walk_t + $urandom_range(50, 400));
      steady = 1'b0;
   endtask

   // One stretch of generated traffic: mostly plausible trajectories.
   task automatic run_segment();
      int kind, len, lim, dx, dy, man;
      kind = $urandom_range(0, 99);
      len  = $urandom_range(3, 14);
      if (kind < 40) begin
         // driving: step size picked per segment
         case ($urandom_range(0, 3))
            0: lim = 3;
            1: lim = 60;
            2: lim = 2000;
            default: lim = 32767;
         endcase
         repeat (len)
            send_sample(walk_x + spread(lim), walk_y + spread(lim),
                        walk_t + $urandom_range(1, 400));
      end else if (kind < 75) begin
         // standing: jitter within the threshold, long enough to brake
         lim = (still_threshold_q > 30) ? 30 : int'(still_threshold_q);
         repeat (len) begin
            dx = $urandom_range(0, lim);
            dy = $urandom_range(0, lim - dx);
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
            send_sample(walk_x + dx, walk_y + dy,
                        walk_t + $urandom_range(0, still_time_q / 4 + 50));
         end
      end else if (kind < 85) begin
         // Manhattan step right at the threshold or one past it
         repeat (len) begin
            man = int'(still_threshold_q) + int'($urandom_range(0, 1));
            dx  = man / 2;
            send_sample(toward_center(walk_x, dx), toward_center(walk_y, man - dx),
                        walk_t + $urandom_range(1, still_time_q / 2 + 50));
         end
      end else if (kind < 93) begin
         // repeated or earlier timestamps
         repeat (len)
            send_sample(walk_x + spread(8), walk_y + spread(8),
                        $urandom_range(0, 1) ? walk_t : walk_t - $urandom_range(1, 5000));
      end else begin
         // noise over the full field ranges
         repeat (len) send_sample($urandom, $urandom, $urandom);
      end
   endtask

   // Phases with different register settings; one phase runs without idling.
   task automatic test_random_traffic();
      int phase, quota;
      phase = 0;
      while (samples_sent < TOTAL_SAMPLES) begin
         wait_idle();
         case (phase % 6)
            0: begin
               write_csr(mtsd_pkg::CSR_STILL_THRESHOLD, mtsd_pkg::STILL_THRESHOLD_RST);
               write_csr(mtsd_pkg::CSR_STILL_TIME, mtsd_pkg::STILL_TIME_RST);
            end
            1: begin
               write_csr(mtsd_pkg::CSR_STILL_THRESHOLD, 16'd0);
               write_csr(mtsd_pkg::CSR_STILL_TIME, 16'd0);
            end
            2: begin
               write_csr(mtsd_pkg::CSR_STILL_THRESHOLD, 16'hFFFF);
               write_csr(mtsd_pkg::CSR_STILL_TIME, 16'hFFFF);
            end
            3: begin
               write_csr(mtsd_pkg::CSR_STILL_THRESHOLD,
                         mtsd_pkg::CFG_W'($urandom_range(0, 50)));
               write_csr(mtsd_pkg::CSR_STILL_TIME,
                         mtsd_pkg::CFG_W'($urandom_range(0, 4000)));
            end
            4: begin
               write_csr(mtsd_pkg::CSR_STILL_THRESHOLD, mtsd_pkg::CFG_W'($urandom));
               write_csr(mtsd_pkg::CSR_STILL_TIME, mtsd_pkg::CFG_W'($urandom));
            end
            default: begin
               write_csr(mtsd_pkg::CSR_STILL_THRESHOLD,
                         mtsd_pkg::CFG_W'($urandom_range(0, 5)));
               write_csr(mtsd_pkg::CSR_STILL_TIME,
                         mtsd_pkg::CFG_W'($urandom_range(100, 1000)));
            end
         endcase
         steady = (phase % 5 == 3);
         quota  = samples_sent + PHASE_SAMPLES;
         while (samples_sent < quota && samples_sent < TOTAL_SAMPLES) run_segment();
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_csr_extremes();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      // catch any response transaction nobody asked for
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
